// ===== hdl/multi_slot_interval_timer_table_assert.svh =====
// Assertion macros shared by the timer table modules.
`ifndef MULTI_SLOT_INTERVAL_TIMER_TABLE_ASSERT_SVH
`define MULTI_SLOT_INTERVAL_TIMER_TABLE_ASSERT_SVH
// Property that must hold in the cycle after a trigger.
`define MSIT_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);
// Property that must hold in the same cycle as a trigger.
`define MSIT_ASSERT_SAME(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);
`endif

// ===== hdl/msit_pkg.sv =====
// Shared types and codes of the timer table.
`default_nettype none
package msit_pkg;
    localparam logic [1:0] CMD_ADVANCE = 2'd0;
    localparam logic [1:0] CMD_ADD     = 2'd1;
    localparam logic [1:0] CMD_MODIFY  = 2'd2;
    localparam logic [1:0] CMD_DELETE  = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_IVL  = 3'd1;
    localparam logic [2:0] ST_ID_USED  = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FIRE,
        S_MIN,
        S_SUM
    } back_state_t;

    // One queued command, already masked to the timer width.
    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] timer_id;
        logic [63:0] interval;
        logic [15:0] repeats;
        logic [63:0] elapsed;
    } cmd_t;

    // One result transaction.
    typedef struct packed {
        logic        kind;
        logic [2:0]  status;
        logic [31:0] result_id;
        logic [39:0] next_remaining;
        logic        any_active;
        logic        last;
    } res_t;
endpackage
`default_nettype wire

// ===== hdl/msit_front.sv =====
// Front end: accepts commands and holds them in a two-entry queue.
`default_nettype none
module msit_front
    import msit_pkg::*;
#(
    parameter int TIME_BITS = 40
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  command,
    input  wire logic [31:0] timer_id,
    input  wire logic [39:0] interval_us,
    input  wire logic [15:0] repeat_count,
    input  wire logic [39:0] elapsed_us,
    output logic             q_valid,
    output cmd_t             q_cmd,
    input  wire logic        q_take
);
    `include "multi_slot_interval_timer_table_assert.svh"

    localparam int TB = (TIME_BITS < 40) ? TIME_BITS : 40;

    cmd_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       do_push, do_pop;
    cmd_t       in_cmd;
    logic [39:0] tmask;

    // Mask times to the configured timer width.
    assign tmask = 40'((41'd1 << TB) - 41'd1);
    always_comb
    begin
        in_cmd.command  = command;
        in_cmd.timer_id = timer_id;
        in_cmd.interval = 64'(interval_us & tmask);
        in_cmd.repeats  = repeat_count;
        in_cmd.elapsed  = 64'(elapsed_us & tmask);
    end

    assign full    = cnt_reg[1];
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd   = mem_reg[rp_reg];
    assign do_push = push && !full;
    assign do_pop  = q_take && q_valid;

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wp_reg] <= in_cmd;
        end
    end

    // Queue pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (do_pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(do_push) - 2'(do_pop);
        end
    end

    `MSIT_ASSERT_SAME(a_cnt_range, clk, rst_n, 1'b1, cnt_reg != 2'd3, "queue count out of range")
    `MSIT_ASSERT_NEXT(a_push_grows, clk, rst_n, do_push && !do_pop, cnt_reg == $past(cnt_reg) + 2'd1, "push lost")
endmodule
`default_nettype wire

// ===== hdl/msit_back.sv =====
// Back end: walks the slot table one slot per cycle, pausing for each fired result, and emits results.
`default_nettype none
module msit_back
    import msit_pkg::*;
#(
    parameter int NUM_SLOTS = 16,
    parameter int TIME_BITS = 40
)(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_valid,
    input  cmd_t      q_cmd,
    output logic      q_take,
    output logic      res_valid,
    output res_t      res,
    input  wire logic res_take
);
    `include "multi_slot_interval_timer_table_assert.svh"

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);

    logic [NUM_SLOTS-1:0] valid_reg, valid_next;
    logic [31:0]          id_mem  [NUM_SLOTS];
    logic [TIME_BITS-1:0] ivl_mem [NUM_SLOTS];
    logic [TIME_BITS-1:0] rem_mem [NUM_SLOTS];
    logic [15:0]          rep_mem [NUM_SLOTS];
    logic [31:0]          next_id_reg, next_id_next;

    back_state_t state_reg, state_next;
    cmd_t        cmd_reg, cmd_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [SW-1:0] slot;
    logic          found_reg, found_next;
    logic [SW-1:0] hit_reg, hit_next;
    logic          free_reg, free_next;
    logic [SW-1:0] fslot_reg, fslot_next;
    logic [2:0]    status_reg, status_next;
    logic [31:0]   rid_reg, rid_next;
    logic          have_reg, have_next;
    logic [TIME_BITS-1:0] best_reg, best_next;
    logic [31:0]   fire_id_reg, fire_id_next;
    res_t          res_reg, res_next;
    logic          rv_reg, rv_next;

    logic [TIME_BITS-1:0] cur_rem, elap, ivl;
    logic [15:0]          cur_rep;
    logic                 cur_v, at_end;
    logic                 wr_rem, wr_ivl, wr_new;
    logic [TIME_BITS-1:0] rem_wdata;
    logic [15:0]          rep_wdata;
    logic                 wr_rep;
    logic [SW-1:0]        wslot;

    assign slot    = idx_reg[SW-1:0];
    assign at_end  = (idx_reg == CW'(NUM_SLOTS));
    assign cur_v   = !at_end && valid_reg[slot];
    assign cur_rem = rem_mem[slot];
    assign cur_rep = rep_mem[slot];
    assign elap    = cmd_reg.elapsed[TIME_BITS-1:0];
    assign ivl     = cmd_reg.interval[TIME_BITS-1:0];
    assign res_valid = rv_reg;
    assign res       = res_reg;

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (q_valid) state_next = S_SCAN;
            S_SCAN:
                if (at_end)
                    state_next = S_MIN;
                else if (cmd_reg.command == CMD_ADVANCE && cur_v && cur_rem <= elap)
                    state_next = S_FIRE;
            S_FIRE: if (!rv_reg || res_take) state_next = S_SCAN;
            S_MIN:  if (at_end) state_next = S_SUM;
            S_SUM:  if (!rv_reg || res_take) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and output logic.
    always_comb
    begin
        cmd_next = cmd_reg; idx_next = idx_reg; found_next = found_reg;
        hit_next = hit_reg; free_next = free_reg; fslot_next = fslot_reg;
        status_next = status_reg; rid_next = rid_reg; have_next = have_reg;
        best_next = best_reg; fire_id_next = fire_id_reg;
        valid_next = valid_reg; next_id_next = next_id_reg;
        res_next = res_reg; rv_next = rv_reg && !res_take;
        q_take = 1'b0;
        wr_rem = 1'b0; wr_ivl = 1'b0; wr_new = 1'b0; wr_rep = 1'b0;
        rem_wdata = '0; rep_wdata = '0; wslot = slot;
        case (state_reg)
            S_IDLE:
                if (q_valid)
                begin
                    q_take = 1'b1; cmd_next = q_cmd; idx_next = '0;
                    found_next = 1'b0; free_next = 1'b0;
                    hit_next = '0; fslot_next = '0;
                end
            S_SCAN:
                if (!at_end)
                begin
                    idx_next = idx_reg + CW'(1);
                    if (cmd_reg.command == CMD_ADVANCE)
                    begin
                        if (cur_v)
                        begin
                            wr_rem = 1'b1;
                            if (cur_rem <= elap)
                            begin
                                rem_wdata = ivl_mem[slot];
                                fire_id_next = id_mem[slot];
                                if (cur_rep != 16'd0)
                                begin
                                    wr_rep = 1'b1;
                                    rep_wdata = cur_rep - 16'd1;
                                    if (cur_rep == 16'd1) valid_next[slot] = 1'b0;
                                end
                            end
                            else
                                rem_wdata = cur_rem - elap;
                        end
                    end
                    else
                    begin
                        if (cur_v && !found_next && id_mem[slot] ==
                            ((cmd_reg.command == CMD_ADD) ? next_id_reg : cmd_reg.timer_id))
                        begin
                            found_next = 1'b1; hit_next = slot;
                        end
                        if (!valid_reg[slot] && !free_reg)
                        begin
                            free_next = 1'b1; fslot_next = slot;
                        end
                    end
                end
                else
                begin
                    // Apply the classified command after the lookup walk.
                    idx_next = '0; have_next = 1'b0; best_next = '0;
                    status_next = ST_OK; rid_next = '0;
                    case (cmd_reg.command)
                        CMD_ADD:
                            if (ivl == '0)
                                status_next = ST_BAD_IVL;
                            else if (found_reg)
                            begin
                                status_next = ST_ID_USED; rid_next = next_id_reg;
                            end
                            else if (!free_reg)
                                status_next = ST_FULL;
                            else
                            begin
                                wr_new = 1'b1; wslot = fslot_reg;
                                valid_next[fslot_reg] = 1'b1;
                                rid_next = next_id_reg;
                                next_id_next = next_id_reg + 32'd1;
                            end
                        CMD_MODIFY, CMD_DELETE:
                        begin
                            rid_next = cmd_reg.timer_id;
                            if (!found_reg)
                                status_next = ST_NOTFOUND;
                            else if (cmd_reg.command == CMD_DELETE)
                                valid_next[hit_reg] = 1'b0;
                            else if (ivl != '0)
                            begin
                                wr_ivl = 1'b1; wslot = hit_reg;
                            end
                        end
                        default: ;
                    endcase
                end
            S_FIRE:
                if (!rv_reg || res_take)
                begin
                    rv_next = 1'b1;
                    res_next = '{kind: 1'b1, status: ST_OK, result_id: fire_id_reg,
                                 next_remaining: 40'd0, any_active: |valid_reg,
                                 last: 1'b0};
                end
            S_MIN:
                if (!at_end)
                begin
                    idx_next = idx_reg + CW'(1);
                    if (cur_v && (!have_reg || cur_rem < best_reg))
                    begin
                        have_next = 1'b1; best_next = cur_rem;
                    end
                end
            S_SUM:
                if (!rv_reg || res_take)
                begin
                    rv_next = 1'b1;
                    res_next = '{kind: 1'b0, status: status_reg, result_id: rid_reg,
                                 next_remaining: 40'(64'(best_reg)),
                                 any_active: |valid_reg, last: 1'b1};
                end
            default: ;
        endcase
    end

    // Slot storage writes.
    always_ff @(posedge clk)
    begin
        if (wr_rem || wr_ivl || wr_new)
        begin
            rem_mem[wslot] <= (wr_rem) ? rem_wdata : ivl;
        end
        if (wr_ivl || wr_new)
        begin
            ivl_mem[wslot] <= ivl;
        end
        if (wr_new)
        begin
            id_mem[wslot]  <= next_id_reg;
            rep_mem[wslot] <= cmd_reg.repeats;
        end
        else if (wr_rep)
        begin
            rep_mem[wslot] <= rep_wdata;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next; hit_reg <= hit_next; fslot_reg <= fslot_next;
        status_reg <= status_next; rid_reg <= rid_next; best_reg <= best_next;
        fire_id_reg <= fire_id_next; res_reg <= res_next;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE; idx_reg <= '0; found_reg <= 1'b0;
            free_reg <= 1'b0; have_reg <= 1'b0; valid_reg <= '0;
            next_id_reg <= '0; rv_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next; idx_reg <= idx_next; found_reg <= found_next;
            free_reg <= free_next; have_reg <= have_next; valid_reg <= valid_next;
            next_id_reg <= next_id_next; rv_reg <= rv_next;
        end
    end

    `MSIT_ASSERT_SAME(a_take_idle, clk, rst_n, q_take, state_reg == S_IDLE, "command taken while busy")
    `MSIT_ASSERT_NEXT(a_sum_last, clk, rst_n, state_reg == S_SUM && state_next == S_IDLE, rv_reg && res_reg.last, "summary not issued")
    `MSIT_ASSERT_SAME(a_idx_range, clk, rst_n, 1'b1, idx_reg <= CW'(NUM_SLOTS), "slot index out of range")
endmodule
`default_nettype wire

// ===== hdl/multi_slot_interval_timer_table.sv =====
// Top level of the interval timer table.
// Usage: commands go in through a queue-style port (push/full); a transaction is
// taken when push is high and full is low. Results come out through a queue-style
// port (empty/pop); the oldest result is on the ports while empty is low and is
// taken when pop is high. A two-entry command queue decouples the front end.
// Each command walks the slot table once to classify or update it, one slot per
// cycle but pausing for each fired result, then once more to find the least
// remaining time.
// The back end handles one command at a time; the slot walk sets the rate.
// An advance yields one fired result per expiring timer, then a summary with
// last set; other commands yield only the summary.
// Reset clears all slots and the id counter; no clearing pass is needed.
// When the receiver stalls, the result register holds and the back end waits;
// the command queue keeps accepting until it is full.
`default_nettype none
module multi_slot_interval_timer_table
    import msit_pkg::*;
#(
    parameter int NUM_SLOTS = 16,
    parameter int TIME_BITS = 40
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  command,
    input  wire logic [31:0] timer_id,
    input  wire logic [39:0] interval_us,
    input  wire logic [15:0] repeat_count,
    input  wire logic [39:0] elapsed_us,
    output logic             empty,
    input  wire logic        pop,
    output logic             kind,
    output logic [2:0]       status,
    output logic [31:0]      result_id,
    output logic [39:0]      next_remaining_us,
    output logic             any_active,
    output logic             last
);
    logic q_valid, q_take, res_valid;
    cmd_t q_cmd;
    res_t res;

    msit_front #(.TIME_BITS(TIME_BITS)) u_front (
        .clk, .rst_n, .push, .full, .command, .timer_id, .interval_us,
        .repeat_count, .elapsed_us, .q_valid, .q_cmd, .q_take
    );

    msit_back #(.NUM_SLOTS(NUM_SLOTS), .TIME_BITS(TIME_BITS)) u_back (
        .clk, .rst_n, .q_valid, .q_cmd, .q_take, .res_valid, .res,
        .res_take(pop)
    );

    assign empty             = !res_valid;
    assign kind              = res.kind;
    assign status            = res.status;
    assign result_id         = res.result_id;
    assign next_remaining_us = res.next_remaining;
    assign any_active        = res.any_active;
    assign last              = res.last;
endmodule
`default_nettype wire
